// File: src/bat_pkg.sv
package bat_pkg;

	localparam int MAX_ENTRIES_DEF = 64;
	localparam int WORD_BITS_DEF   = 32;

	localparam int OP_W      = 3;
	localparam int POS_W     = 7;
	localparam int DATA_W    = 32;
	localparam int ST_W      = 3;
	localparam int FPOS_W    = 6;
	localparam int CNT_OUT_W = 7;
	localparam int CAP_W     = 7;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND    = 3'd0,
		OP_INSERT    = 3'd1,
		OP_DELETE    = 3'd2,
		OP_OVERWRITE = 3'd3,
		OP_READ      = 3'd4,
		OP_FIND      = 3'd5
	} op_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_BAD_INDEX = 3'd3,
		ST_NOT_FOUND = 3'd4
	} status_t;

	typedef struct packed {
		status_t                   status;
		logic signed [DATA_W-1:0]  read_data;
		logic [FPOS_W-1:0]         found_position;
		logic [CNT_OUT_W-1:0]      entry_count;
		logic                      is_full;
		logic                      is_empty;
	} res_t;

endpackage

// File: src/bounded_array_table.sv
// Bounded array table: an ordered list of signed words kept in one entry RAM.
// Input channel (in_valid/in_ready) carries one request beat: opcode, position,
// data_word. Output channel (out_valid/out_ready) returns one result beat per
// request: status, read_data, found_position, entry_count, is_full, is_empty.
// cfg_we writes cfg_wdata into the capacity register; write it only while idle.
// One request is in flight at a time; in_ready is high only while idle.
// Path from accept to the result beat, n the count before the request:
//   append, overwrite, failed or unused requests: straight to the result
//   read: the read state captures the registered RAM output
//   insert: entries position to n-1 move up one slot, highest first, one RAM read
//     per moved entry; then the word is written at position
//   delete: entries after position move down one slot, lowest first
//   find: compares entries from index 0 up and stops at the first match
// The next request is taken only once the result has left the sequencer.
// The entry RAM, one read and one write a cycle, moves or compares one entry a cycle.
// The result beat sits in an output register, so a new request is taken while
// it waits; a stalled receiver holds the next result inside the sequencer.
// Reset empties the table and sets the capacity to 64; no RAM clearing pass.
module bounded_array_table #(
	parameter int MAX_ENTRIES = bat_pkg::MAX_ENTRIES_DEF,
	parameter int WORD_BITS   = bat_pkg::WORD_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bat_pkg::CAP_W-1:0]            cfg_wdata,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [bat_pkg::OP_W-1:0]             opcode,
	input  logic [bat_pkg::POS_W-1:0]            position,
	input  logic signed [bat_pkg::DATA_W-1:0]    data_word,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [bat_pkg::ST_W-1:0]             status,
	output logic signed [bat_pkg::DATA_W-1:0]    read_data,
	output logic [bat_pkg::FPOS_W-1:0]           found_position,
	output logic [bat_pkg::CNT_OUT_W-1:0]        entry_count,
	output logic                                 is_full,
	output logic                                 is_empty
);
	import bat_pkg::*;

	logic [CAP_W-1:0] capacity_q;
	logic             out_valid_q;
	res_t             out_q;
	res_t             res;
	logic             res_valid;
	logic             res_ready;

	assign res_ready = !out_valid_q || out_ready;

	bat_engine #(
		.MAX_ENTRIES(MAX_ENTRIES),
		.WORD_BITS  (WORD_BITS)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.capacity (capacity_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.position (position),
		.data_word(data_word),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (res_ready) begin
				out_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_q.status;
	assign read_data      = out_q.read_data;
	assign found_position = out_q.found_position;
	assign entry_count    = out_q.entry_count;
	assign is_full        = out_q.is_full;
	assign is_empty       = out_q.is_empty;

endmodule

// File: src/bat_ram.sv
module bat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/bat_engine.sv
module bat_engine #(
	parameter int MAX_ENTRIES = bat_pkg::MAX_ENTRIES_DEF,
	parameter int WORD_BITS   = bat_pkg::WORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [bat_pkg::CAP_W-1:0]           capacity,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [bat_pkg::OP_W-1:0]            opcode,
	input  logic [bat_pkg::POS_W-1:0]           position,
	input  logic signed [bat_pkg::DATA_W-1:0]   data_word,
	output logic                                res_valid,
	input  logic                                res_ready,
	output bat_pkg::res_t                       res
);
	import bat_pkg::*;

	localparam int AW    = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_READ = 6'b000010,
		S_UP   = 6'b000100,
		S_DOWN = 6'b001000,
		S_FIND = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t                  state_q, state_d;
	logic [CNT_W-1:0]        count_q, count_d;
	logic                    pend_q, pend_d;
	logic [CMP_W-1:0]        idx_q, idx_d;
	logic [CMP_W-1:0]        pos_q, pos_d;
	logic [AW-1:0]           wdst_q, wdst_d;
	logic [AW-1:0]           fpos_q, fpos_d;
	logic [AW-1:0]           cmp_q, cmp_d;
	logic [WORD_BITS-1:0]    word_q, word_d;
	logic signed [WORD_BITS-1:0] rdata_q, rdata_d;
	status_t                 status_q, status_d;

	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic [WORD_BITS-1:0]    mem_wdata;
	logic [AW-1:0]           mem_raddr;
	logic [WORD_BITS-1:0]    mem_rdata;

	logic signed [WORD_BITS-1:0] word_in;
	logic [CMP_W-1:0]        pos_x;
	logic [CMP_W-1:0]        cnt_x;
	logic [CMP_W-1:0]        cap_x;
	logic                    full_now;
	logic [CMP_W-1:0]        idx_m1;

	assign word_in  = WORD_BITS'(data_word);
	assign pos_x    = CMP_W'(position);
	assign cnt_x    = CMP_W'(count_q);
	assign cap_x    = CMP_W'(capacity);
	assign full_now = (cnt_x >= cap_x) || (count_q == CNT_W'(MAX_ENTRIES));
	assign idx_m1   = CMP_W'(idx_q - 1'b1);

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);

	always_comb begin
		res.status         = status_q;
		res.read_data      = DATA_W'(rdata_q);
		res.found_position = FPOS_W'(fpos_q);
		res.entry_count    = CNT_OUT_W'(count_q);
		res.is_full        = full_now;
		res.is_empty       = (count_q == '0);
	end

	bat_ram #(
		.WIDTH(WORD_BITS),
		.DEPTH(MAX_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		pend_d    = pend_q;
		idx_d     = idx_q;
		pos_d     = pos_q;
		wdst_d    = wdst_q;
		fpos_d    = fpos_q;
		cmp_d     = cmp_q;
		word_d    = word_q;
		rdata_d   = rdata_q;
		status_d  = status_q;
		mem_we    = 1'b0;
		mem_waddr = wdst_q;
		mem_wdata = mem_rdata;
		mem_raddr = idx_q[AW-1:0];

		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					status_d = ST_OK;
					rdata_d  = '0;
					fpos_d   = '0;
					word_d   = word_in;
					pos_d    = pos_x;
					pend_d   = 1'b0;
					state_d  = S_DONE;
					case (op_t'(opcode))
						OP_APPEND: begin
							if (full_now) begin
								status_d = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = count_q[AW-1:0];
								mem_wdata = word_in;
								count_d   = CNT_W'(count_q + 1'b1);
							end
						end
						OP_INSERT: begin
							if (full_now) begin
								status_d = ST_FULL;
							end else if (pos_x > cnt_x) begin
								status_d = ST_BAD_INDEX;
							end else begin
								idx_d   = cnt_x;
								state_d = S_UP;
							end
						end
						OP_DELETE: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else if (pos_x >= cnt_x) begin
								status_d = ST_BAD_INDEX;
							end else begin
								idx_d   = CMP_W'(pos_x + 1'b1);
								state_d = S_DOWN;
							end
						end
						OP_OVERWRITE: begin
							if (pos_x >= cnt_x) begin
								status_d = ST_BAD_INDEX;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = pos_x[AW-1:0];
								mem_wdata = word_in;
							end
						end
						OP_READ: begin
							mem_raddr = pos_x[AW-1:0];
							if (pos_x >= cnt_x) begin
								status_d = ST_BAD_INDEX;
							end else begin
								state_d = S_READ;
							end
						end
						OP_FIND: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								idx_d   = '0;
								state_d = S_FIND;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				rdata_d = mem_rdata;
				state_d = S_DONE;
			end
			S_UP: begin
				mem_raddr = idx_m1[AW-1:0];
				if (pend_q) begin
					mem_we = 1'b1;
				end else if (idx_q == pos_q) begin
					mem_we    = 1'b1;
					mem_waddr = pos_q[AW-1:0];
					mem_wdata = word_q;
				end
				if (idx_q > pos_q) begin
					wdst_d = idx_q[AW-1:0];
					idx_d  = idx_m1;
					pend_d = 1'b1;
				end else if (pend_q) begin
					pend_d = 1'b0;
				end else begin
					count_d = CNT_W'(count_q + 1'b1);
					state_d = S_DONE;
				end
			end
			S_DOWN: begin
				mem_we = pend_q;
				if (idx_q < cnt_x) begin
					wdst_d = idx_m1[AW-1:0];
					idx_d  = CMP_W'(idx_q + 1'b1);
					pend_d = 1'b1;
				end else if (pend_q) begin
					pend_d = 1'b0;
				end else begin
					count_d = CNT_W'(count_q - 1'b1);
					state_d = S_DONE;
				end
			end
			S_FIND: begin
				if (pend_q && (mem_rdata == word_q)) begin
					fpos_d   = cmp_q;
					status_d = ST_OK;
					pend_d   = 1'b0;
					state_d  = S_DONE;
				end else if (idx_q < cnt_x) begin
					cmp_d  = idx_q[AW-1:0];
					idx_d  = CMP_W'(idx_q + 1'b1);
					pend_d = 1'b1;
				end else if (pend_q) begin
					pend_d = 1'b0;
				end else begin
					status_d = ST_NOT_FOUND;
					state_d  = S_DONE;
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		pos_q    <= pos_d;
		wdst_q   <= wdst_d;
		fpos_q   <= fpos_d;
		cmp_q    <= cmp_d;
		word_q   <= word_d;
		rdata_q  <= rdata_d;
		status_q <= status_d;
	end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import bat_pkg::*;

	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;
	localparam int TABLE_DEPTH = MAX_ENTRIES_DEF;
	localparam int STUCK_LIMIT = 3000;
	localparam int PHASE_ITEMS = 118;
	localparam int PHASE_COUNT = 11;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_MIXED} mix_t;

	typedef struct {
		logic [OP_W-1:0]           op;
		logic [POS_W-1:0]          pos;
		logic signed [DATA_W-1:0]  word;
	} request_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [CAP_W-1:0]              cfg_wdata = '0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [OP_W-1:0]               opcode = '0;
	logic [POS_W-1:0]              position = '0;
	logic signed [DATA_W-1:0]      data_word = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [ST_W-1:0]               status;
	logic signed [DATA_W-1:0]      read_data;
	logic [FPOS_W-1:0]             found_position;
	logic [CNT_OUT_W-1:0]          entry_count;
	logic                          is_full;
	logic                          is_empty;

	request_t                      pending[$];
	res_t                          expected_results[$];
	logic                          in_beat = 1'b0;
	logic                          calm = 1'b0;
	int                            in_flight = 0;
	int                            mismatches = 0;
	int                            stuck_cycles = 0;

	logic signed [DATA_W-1:0]      table_words [TABLE_DEPTH];
	int                            table_count = 0;
	logic [CAP_W-1:0]              capacity_reg = CAP_RESET;

	logic [CAP_W-1:0] cap_plan [PHASE_COUNT] =
		'{7'd2, 7'd127, 7'd64, 7'd0, 7'd1, 7'd5, 7'd64, 7'd40, 7'd3, 7'd127, 7'd17};
	mix_t mix_plan [PHASE_COUNT] = '{MIX_MIXED, MIX_FILL, MIX_DRAIN, MIX_MIXED, MIX_MIXED,
		MIX_MIXED, MIX_FILL, MIX_MIXED, MIX_DRAIN, MIX_MIXED, MIX_FILL};
	int cut_table [3][6] = '{'{35, 65, 73, 81, 89, 98}, '{8, 16, 61, 71, 83, 98},
		'{20, 37, 57, 69, 83, 98}};
	logic signed [DATA_W-1:0] word_pool [8] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0,
		32'hffff_ffff, 32'h1, 32'h5, 32'd1000, -32'sd1000};

	bounded_array_table dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.position       (position),
		.data_word      (data_word),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.read_data      (read_data),
		.found_position (found_position),
		.entry_count    (entry_count),
		.is_full        (is_full),
		.is_empty       (is_empty)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic res_t table_predict(input logic [OP_W-1:0] op,
			input logic [POS_W-1:0] pos, input logic signed [DATA_W-1:0] word);
		res_t r;
		int lim;
		int p;
		int i;
		lim = (capacity_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(capacity_reg);
		p = int'(pos);
		r = '0;
		r.status = ST_OK;
		case (op)
		OP_APPEND: begin
			if (table_count >= lim) begin
				r.status = ST_FULL;
			end else begin
				table_words[table_count] = word;
				table_count++;
			end
		end
		OP_INSERT: begin
			if (table_count >= lim) begin
				r.status = ST_FULL;
			end else if (p > table_count) begin
				r.status = ST_BAD_INDEX;
			end else begin
				for (i = table_count; i > p; i--)
					table_words[i] = table_words[i - 1];
				table_words[p] = word;
				table_count++;
			end
		end
		OP_DELETE: begin
			if (table_count == 0) begin
				r.status = ST_EMPTY;
			end else if (p >= table_count) begin
				r.status = ST_BAD_INDEX;
			end else begin
				for (i = p; i + 1 < table_count; i++)
					table_words[i] = table_words[i + 1];
				table_count--;
			end
		end
		OP_OVERWRITE: begin
			if (p >= table_count)
				r.status = ST_BAD_INDEX;
			else
				table_words[p] = word;
		end
		OP_READ: begin
			if (p >= table_count)
				r.status = ST_BAD_INDEX;
			else
				r.read_data = table_words[p];
		end
		OP_FIND: begin
			if (table_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.status = ST_NOT_FOUND;
				for (i = 0; i < table_count; i++) begin
					if (r.status == ST_NOT_FOUND && table_words[i] == word) begin
						r.status = ST_OK;
						r.found_position = FPOS_W'(i);
					end
				end
			end
		end
		default: begin
		end
		endcase
		r.entry_count = CNT_OUT_W'(table_count);
		r.is_full = (table_count >= lim);
		r.is_empty = (table_count == 0);
		return r;
	endfunction

	function automatic request_t make_request(input mix_t mix);
		request_t req;
		int r;
		int k;
		r = $urandom_range(0, 99);
		req.op = (r < 99) ? OP_SPARE_LO : OP_SPARE_HI;
		for (k = 5; k >= 0; k--) begin
			if (r < cut_table[mix][k])
				req.op = OP_W'(k);
		end
		r = $urandom_range(0, 99);
		if (r < 75) begin
			if (table_count == 0)
				req.pos = POS_W'($urandom_range(0, 2));
			else if (req.op == OP_INSERT)
				req.pos = POS_W'($urandom_range(0, table_count));
			else
				req.pos = POS_W'($urandom_range(0, table_count - 1));
		end else if (r < 90) begin
			req.pos = POS_W'($urandom_range(0, 66));
		end else begin
			req.pos = POS_W'($urandom_range(0, 127));
		end
		if ($urandom_range(0, 99) < 60)
			req.word = word_pool[$urandom_range(0, 7)];
		else
			req.word = $urandom;
		return req;
	endfunction

	task automatic queue_request(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
			input logic signed [DATA_W-1:0] word);
		request_t req;
		req.op = op;
		req.pos = pos;
		req.word = word;
		pending.push_back(req);
		in_flight++;
	endtask

	task automatic wait_idle();
		while (in_flight != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	always @(negedge clk) begin
		request_t req;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_beat) begin
			if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
				req = pending.pop_front();
				in_valid <= 1'b1;
				opcode <= req.op;
				position <= req.pos;
				data_word <= req.word;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		out_ready <= arst_n && (calm || $urandom_range(0, 99) >= 25);
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_beat <= 1'b0;
		end else begin
			in_beat <= in_valid && in_ready;
			if (in_valid && in_ready)
				expected_results.push_back(table_predict(opcode, position, data_word));
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat with no request outstanding");
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					in_flight--;
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatches++;
					end
					if (read_data !== want.read_data) begin
						$error("read_data: expected %0d, got %0d", want.read_data, read_data);
						mismatches++;
					end
					if (found_position !== want.found_position) begin
						$error("found_position: expected %0d, got %0d",
							want.found_position, found_position);
						mismatches++;
					end
					if (entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
						mismatches++;
					end
					if (is_full !== want.is_full) begin
						$error("is_full: expected %0d, got %0d", want.is_full, is_full);
						mismatches++;
					end
					if (is_empty !== want.is_empty) begin
						$error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
						mismatches++;
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
				stuck_cycles <= 0;
			end else if (stuck_cycles >= STUCK_LIMIT) begin
				$display("testbench failed");
				$finish;
			end else begin
				stuck_cycles <= stuck_cycles + 1;
			end
		end
	end

	initial begin
		int ph;
		int n;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		queue_request(OP_DELETE, 7'd0, 32'd0);
		queue_request(OP_FIND, 7'd0, 32'd0);
		queue_request(OP_READ, 7'd0, 32'd0);
		queue_request(OP_OVERWRITE, 7'd0, 32'd9);
		queue_request(OP_INSERT, 7'd1, 32'd9);
		queue_request(OP_INSERT, 7'd0, 32'h8000_0000);
		queue_request(OP_APPEND, 7'd0, 32'h7fff_ffff);
		queue_request(OP_INSERT, 7'd1, 32'hffff_ffff);
		queue_request(OP_INSERT, 7'd0, 32'h0);
		queue_request(OP_INSERT, 7'd5, 32'd3);
		queue_request(OP_READ, 7'd3, 32'd0);
		queue_request(OP_READ, 7'd0, 32'd0);
		queue_request(OP_OVERWRITE, 7'd2, 32'd12345);
		queue_request(OP_FIND, 7'd0, 32'h7fff_ffff);
		queue_request(OP_FIND, 7'd0, 32'd555);
		queue_request(OP_DELETE, 7'd1, 32'd0);
		queue_request(OP_DELETE, 7'd5, 32'd0);
		queue_request(OP_READ, 7'd127, 32'd0);
		queue_request(OP_OVERWRITE, 7'd127, 32'h5a5a_a5a5);
		queue_request(OP_SPARE_LO, 7'd0, 32'd1);
		queue_request(OP_SPARE_HI, 7'd127, 32'hffff_ffff);
		queue_request(OP_DELETE, 7'd2, 32'd0);
		queue_request(OP_READ, 7'd1, 32'd0);

		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			wait_idle();
			cfg_we <= 1'b1;
			cfg_wdata <= cap_plan[ph];
			capacity_reg = cap_plan[ph];
			@(negedge clk);
			cfg_we <= 1'b0;
			calm = (ph == 6);
			for (n = 0; n < PHASE_ITEMS; n++) begin
				while (pending.size() >= 2)
					@(negedge clk);
				pending.push_back(make_request(mix_plan[ph]));
				in_flight++;
			end
		end

		wait_idle();
		calm = 1'b0;
		repeat (100) @(posedge clk);
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// File: filelist.f
src/bat_pkg.sv
src/bat_ram.sv
src/bat_engine.sv
src/bounded_array_table.sv
sim/testbench.sv
